### src/rita_pkg.sv
package rita_pkg;

    // Default width of the value that is converted.
    localparam int VALUE_BITS_DEF = 32;

    // Width of the radix field and its legal range.
    localparam int RADIX_W = 6;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // Digit values from this one upwards are shown as letters.
    localparam logic [RADIX_W-1:0] DEC_LIMIT = 6'd10;

    typedef logic [7:0] t_char;

    localparam t_char CHAR_ZERO = 8'h30;
    localparam t_char CHAR_A    = 8'h41;
    localparam t_char CHAR_CR   = 8'h0D;
    localparam t_char CHAR_LF   = 8'h0A;

endpackage

### src/rita_in_if.sv
interface rita_in_if #(
    parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF
);
    import rita_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

### src/rita_out_if.sv
interface rita_out_if;
    import rita_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_code;
    logic  last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

### src/radix_integer_to_ascii_core.sv
// Flow: the item is taken in, then each digit is the remainder of a full pass of the shared
// restoring divider (one quotient bit per cycle), then one character per cycle goes out
// while the output is not stalled. The divider loop limits throughput: a new item is
// taken only once the last one is through. Input ready is high only while idle.
// Reset is synchronous and active low: the sequencer goes idle, the output register
// empties and the line-end register returns to 1. The digit store needs no clearing.
module radix_integer_to_ascii_core #(
    parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    rita_in_if.sink           i_in,
    rita_out_if.source        o_out
);
    import rita_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int BIT_W = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DIGIT,
        S_CR,
        S_LF
    } t_state;

    t_state                r_state;
    logic                  r_append;
    logic [VALUE_BITS-1:0] r_val;
    logic [RADIX_W-1:0]    r_radix;
    logic [RADIX_W-1:0]    r_rem;
    logic [BIT_W-1:0]      r_bit;
    logic [CNT_W-1:0]      r_ndig;
    logic                  r_out_valid;
    logic                  r_out_last;
    t_char                 r_out_char;
    t_char                 r_digits [VALUE_BITS];

    logic [RADIX_W:0]      trial;
    logic                  trial_ge;
    logic [RADIX_W-1:0]    n_rem;
    logic [VALUE_BITS-1:0] n_quo;
    logic                  last_bit;
    t_char                 n_digit_char;
    logic [RADIX_W-1:0]    radix_clamped;
    logic                  in_xfer;
    logic                  out_free;
    logic                  load_en;
    logic                  mem_wr;
    logic [CNT_W-1:0]      rd_cnt;

    // Shared divider step: bring in the next dividend bit and subtract the radix if it fits.
    always_comb begin
        trial    = {r_rem, r_val[VALUE_BITS-1]};
        trial_ge = (trial >= {1'b0, r_radix});
        n_rem    = trial_ge ? RADIX_W'(trial - {1'b0, r_radix}) : trial[RADIX_W-1:0];
        n_quo    = {r_val[VALUE_BITS-2:0], trial_ge};
        last_bit = (r_bit == BIT_W'(VALUE_BITS - 1));
    end

    // The finished remainder becomes a digit or a letter.
    always_comb begin
        if (n_rem < DEC_LIMIT) begin
            n_digit_char = CHAR_ZERO + t_char'(n_rem);
        end else begin
            n_digit_char = CHAR_A + t_char'(n_rem - DEC_LIMIT);
        end
    end

    // Radix outside the legal range is clamped to its nearer end.
    always_comb begin
        if (i_in.radix < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (i_in.radix > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = i_in.radix;
        end
    end

    // Handshake and store control.
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign load_en  = out_free && (r_state == S_DIGIT || r_state == S_CR || r_state == S_LF);
    assign mem_wr   = (r_state == S_DIV) && last_bit;
    assign rd_cnt   = r_ndig - CNT_W'(1);

    // Sequencer, divider registers and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_append    <= 1'b1;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_append <= i_cfg_wr_data;
            end
            // The output register fills when a character is loaded and empties on a transfer.
            if (load_en) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_val   <= i_in.value;
                        r_radix <= radix_clamped;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_ndig  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_val <= n_quo;
                    if (last_bit) begin
                        r_rem  <= '0;
                        r_bit  <= '0;
                        r_ndig <= r_ndig + CNT_W'(1);
                        if (n_quo == '0) begin
                            r_state <= S_DIGIT;
                        end
                    end else begin
                        r_rem <= n_rem;
                        r_bit <= r_bit + BIT_W'(1);
                    end
                end
                S_DIGIT: begin
                    if (out_free) begin
                        r_out_last  <= (r_ndig == CNT_W'(1)) && !r_append;
                        r_ndig      <= rd_cnt;
                        if (r_ndig == CNT_W'(1)) begin
                            r_state <= r_append ? S_CR : S_IDLE;
                        end
                    end
                end
                S_CR: begin
                    if (out_free) begin
                        r_out_last  <= 1'b0;
                        r_state     <= S_LF;
                    end
                end
                S_LF: begin
                    if (out_free) begin
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Digit store, written least significant digit first and read back in reverse.
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_digits[r_ndig[IDX_W-1:0]] <= n_digit_char;
        end
        if (load_en) begin
            if (r_state == S_DIGIT) begin
                r_out_char <= r_digits[rd_cnt[IDX_W-1:0]];
            end else if (r_state == S_CR) begin
                r_out_char <= CHAR_CR;
            end else begin
                r_out_char <= CHAR_LF;
            end
        end
    end

    // Port drive.
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_char;
    assign o_out.last_char = r_out_last;

`ifndef ASSERT_OFF
    // The partial remainder always stays below the radix.
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_radix))
        else $error("remainder not below radix");

    // The radix in use lies inside the legal range.
    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_radix >= RADIX_MIN && r_radix <= RADIX_MAX))
        else $error("radix outside legal range");

    // No more digits are stored than the value width allows.
    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_ndig <= CNT_W'(VALUE_BITS)))
        else $error("digit count overflow");

    // Digit emission never starts with an empty store.
    a_digit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (r_ndig != '0))
        else $error("digit emission with no digits");

    // A flagged final character is never pending while the line end is being sent.
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_state != S_CR && r_state != S_LF))
        else $error("final character while emission continues");
`endif

endmodule
